### hdl/crtq_pkg.sv
package crtq_pkg;

  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned STATUS_W = 3;

  // request codes
  localparam logic [FUNC_W-1:0] FUNC_ENQ    = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_DEQ    = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_APPENDED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_MERGED   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_WHOLE    = 3'd4;
  localparam logic [STATUS_W-1:0] ST_MARKER   = 3'd5;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd6;
  localparam logic [STATUS_W-1:0] ST_REMOVED  = 3'd7;

  // sequencer states, one-hot
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RD   = 4'b0010,
    S_CHK  = 4'b0100,
    S_RESP = 4'b1000
  } state_e;

endpackage

### hdl/crtq_req_if.sv
interface crtq_req_if #(
  parameter int unsigned ID_BITS    = 8,
  parameter int unsigned INDEX_BITS = 21
);
  import crtq_pkg::*;

  logic                         valid;
  logic                         ready;
  logic [FUNC_W-1:0]            func;
  logic [ID_BITS-1:0]           task_id;
  logic signed [INDEX_BITS-1:0] range_begin;
  logic signed [INDEX_BITS-1:0] range_end;

  modport source (output valid, func, task_id, range_begin, range_end, input ready);
  modport sink   (input valid, func, task_id, range_begin, range_end, output ready);

endinterface

### hdl/crtq_rsp_if.sv
interface crtq_rsp_if #(
  parameter int unsigned ID_BITS    = 8,
  parameter int unsigned INDEX_BITS = 21,
  parameter int unsigned CNT_BITS   = 5
);
  import crtq_pkg::*;

  logic                         valid;
  logic                         ready;
  logic [STATUS_W-1:0]          status;
  logic [ID_BITS-1:0]           out_id;
  logic signed [INDEX_BITS-1:0] out_begin;
  logic signed [INDEX_BITS-1:0] out_end;
  logic [CNT_BITS-1:0]          removed_count;
  logic [CNT_BITS-1:0]          occupancy;

  modport source (output valid, status, out_id, out_begin, out_end, removed_count, occupancy,
                  input ready);
  modport sink   (input valid, status, out_id, out_begin, out_end, removed_count, occupancy,
                  output ready);

endinterface

### hdl/crtq_ram.sv
module crtq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### hdl/coalescing_range_task_queue.sv
// Coalescing range task queue. A FIFO of up to QUEUE_DEPTH requests, each a
// task id with a signed index range. Enqueue (func 0) folds the request into
// the first queued entry of the same id by widening its range, drops an
// end-of-batch marker (id 0) that would follow another marker, appends
// otherwise, or reports "dropped full". Dequeue (func 1) pops the head and
// classifies it as range, whole or marker. Remove (func 2) deletes every entry
// of an id and closes the gaps, keeping order. Every request gives exactly one
// response transaction carrying the status and the occupancy afterwards.
// Entries live in a circular buffer in one single-port-read, single-port-write
// RAM with a registered read; each entry visited by a merge search or a
// removal takes a read state, then a check/write state. The sequencer
// returns to idle before the next request is taken.
// A new request is taken once the previous response is parked in the output
// register, even if the sink has not yet taken it. No clearing pass at reset.
module coalescing_range_task_queue #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned ID_BITS     = 8,
  parameter int unsigned INDEX_BITS  = 21
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  crtq_req_if.sink   req_i,
  crtq_rsp_if.source rsp_o
);
  import crtq_pkg::*;

  localparam int unsigned PTR_W   = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SUM_W   = CNT_W + 1;
  localparam int unsigned ENTRY_W = ID_BITS + 2 * INDEX_BITS;

  // entry layout: {id, begin, end}
  localparam int unsigned HI_LSB = 0;
  localparam int unsigned LO_LSB = INDEX_BITS;
  localparam int unsigned ID_LSB = 2 * INDEX_BITS;

  state_e state_q, state_d;

  // latched request
  logic [FUNC_W-1:0]            op_q, op_d;
  logic [ID_BITS-1:0]           id_q, id_d;
  logic signed [INDEX_BITS-1:0] lo_q, lo_d;
  logic signed [INDEX_BITS-1:0] hi_q, hi_d;

  // queue bookkeeping
  logic [PTR_W-1:0] head_q, head_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] rd_q, rd_d;   // scan offset from head
  logic [CNT_W-1:0] wr_q, wr_d;   // compaction write offset
  logic [CNT_W-1:0] rem_q, rem_d; // entries deleted so far

  // pending result
  logic [STATUS_W-1:0]          res_status_q, res_status_d;
  logic [ID_BITS-1:0]           res_id_q, res_id_d;
  logic signed [INDEX_BITS-1:0] res_lo_q, res_lo_d;
  logic signed [INDEX_BITS-1:0] res_hi_q, res_hi_d;

  // output register
  logic                         out_valid_q, out_valid_d;
  logic [STATUS_W-1:0]          out_status_q;
  logic [ID_BITS-1:0]           out_id_q;
  logic signed [INDEX_BITS-1:0] out_lo_q;
  logic signed [INDEX_BITS-1:0] out_hi_q;
  logic [CNT_W-1:0]             out_rem_q;
  logic [CNT_W-1:0]             out_occ_q;
  logic                         out_load;

  // RAM port
  logic               ram_we;
  logic [PTR_W-1:0]   ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0] ram_wdata, ram_rdata;
  logic [CNT_W-1:0]   wr_off;
  logic [SUM_W-1:0]   rd_sum, wr_sum;

  logic [ID_BITS-1:0]           ent_id;
  logic signed [INDEX_BITS-1:0] ent_lo, ent_hi;
  logic signed [INDEX_BITS-1:0] mrg_lo, mrg_hi;

  assign ent_id = ram_rdata[ID_LSB +: ID_BITS];
  assign ent_lo = ram_rdata[LO_LSB +: INDEX_BITS];
  assign ent_hi = ram_rdata[HI_LSB +: INDEX_BITS];

  assign mrg_lo = (ent_lo > lo_q) ? lo_q : ent_lo;
  assign mrg_hi = (ent_hi < hi_q) ? hi_q : ent_hi;

  // logical offset -> physical slot, one wrap at most
  always_comb begin
    rd_sum = SUM_W'(head_q) + SUM_W'(rd_q);
    wr_sum = SUM_W'(head_q) + SUM_W'(wr_off);
    ram_raddr = (rd_sum >= SUM_W'(QUEUE_DEPTH)) ? PTR_W'(rd_sum - SUM_W'(QUEUE_DEPTH))
                                                : PTR_W'(rd_sum);
    ram_waddr = (wr_sum >= SUM_W'(QUEUE_DEPTH)) ? PTR_W'(wr_sum - SUM_W'(QUEUE_DEPTH))
                                                : PTR_W'(wr_sum);
  end

  crtq_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign req_i.ready = (state_q == S_IDLE);
  assign out_load    = (state_q == S_RESP) && (!out_valid_q || rsp_o.ready);

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    id_d         = id_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    head_d       = head_q;
    count_d      = count_q;
    rd_d         = rd_q;
    wr_d         = wr_q;
    rem_d        = rem_q;
    res_status_d = res_status_q;
    res_id_d     = res_id_q;
    res_lo_d     = res_lo_q;
    res_hi_d     = res_hi_q;
    ram_we       = 1'b0;
    wr_off       = rd_q;
    ram_wdata    = {id_q, lo_q, hi_q};

    unique case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          op_d     = req_i.func;
          id_d     = req_i.task_id;
          lo_d     = req_i.range_begin;
          hi_d     = req_i.range_end;
          wr_d     = '0;
          rem_d    = '0;
          res_id_d = '0;
          res_lo_d = '0;
          res_hi_d = '0;
          // a marker only looks at the tail entry
          if (req_i.func == FUNC_ENQ && req_i.task_id == '0 && count_q != '0) begin
            rd_d = count_q - CNT_W'(1);
          end else begin
            rd_d = '0;
          end
          state_d = S_RD;
        end
      end

      S_RD: begin
        unique case (op_q)
          FUNC_ENQ: begin
            if (rd_q < count_q) begin
              state_d = S_CHK;
            end else if (count_q == CNT_W'(QUEUE_DEPTH)) begin
              res_status_d = ST_FULL;
              state_d      = S_RESP;
            end else begin
              // append at the tail
              ram_we       = 1'b1;
              wr_off       = count_q;
              count_d      = count_q + CNT_W'(1);
              res_status_d = ST_APPENDED;
              state_d      = S_RESP;
            end
          end
          FUNC_DEQ: begin
            if (count_q != '0) begin
              state_d = S_CHK;
            end else begin
              res_status_d = ST_EMPTY;
              state_d      = S_RESP;
            end
          end
          FUNC_REMOVE: begin
            if (rd_q < count_q) begin
              state_d = S_CHK;
            end else begin
              count_d      = wr_q;
              res_status_d = ST_REMOVED;
              state_d      = S_RESP;
            end
          end
          default: begin
            res_status_d = ST_EMPTY;
            state_d      = S_RESP;
          end
        endcase
      end

      S_CHK: begin
        unique case (op_q)
          FUNC_ENQ: begin
            if (ent_id == id_q) begin
              // markers merge without touching the stored bounds
              if (id_q != '0) begin
                ram_we    = 1'b1;
                wr_off    = rd_q;
                ram_wdata = {ent_id, mrg_lo, mrg_hi};
              end
              res_status_d = ST_MERGED;
              state_d      = S_RESP;
            end else begin
              rd_d    = rd_q + CNT_W'(1);
              state_d = S_RD;
            end
          end
          FUNC_DEQ: begin
            head_d   = (head_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + PTR_W'(1);
            count_d  = count_q - CNT_W'(1);
            res_id_d = ent_id;
            res_lo_d = ent_lo;
            res_hi_d = ent_hi;
            if (ent_id == '0) begin
              res_status_d = ST_MARKER;
            end else if (ent_hi > 0) begin
              // single-index range: begin one below
              if (ent_lo == ent_hi && ent_lo > 0) begin
                res_lo_d = ent_lo - INDEX_BITS'(1);
              end
              res_status_d = ST_RANGE;
            end else begin
              res_status_d = ST_WHOLE;
            end
            state_d = S_RESP;
          end
          default: begin
            // compaction: survivors slide down to the write offset
            if (ent_id == id_q) begin
              rem_d = rem_q + CNT_W'(1);
            end else begin
              ram_we    = 1'b1;
              wr_off    = wr_q;
              ram_wdata = ram_rdata;
              wr_d      = wr_q + CNT_W'(1);
            end
            rd_d    = rd_q + CNT_W'(1);
            state_d = S_RD;
          end
        endcase
      end

      S_RESP: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    id_q         <= id_d;
    lo_q         <= lo_d;
    hi_q         <= hi_d;
    rd_q         <= rd_d;
    wr_q         <= wr_d;
    rem_q        <= rem_d;
    res_status_q <= res_status_d;
    res_id_q     <= res_id_d;
    res_lo_q     <= res_lo_d;
    res_hi_q     <= res_hi_d;
    if (out_load) begin
      out_status_q <= res_status_q;
      out_id_q     <= res_id_q;
      out_lo_q     <= res_lo_q;
      out_hi_q     <= res_hi_q;
      out_rem_q    <= (op_q == FUNC_REMOVE) ? rem_q : '0;
      out_occ_q    <= count_q;
    end
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.status        = out_status_q;
  assign rsp_o.out_id        = out_id_q;
  assign rsp_o.out_begin     = out_lo_q;
  assign rsp_o.out_end       = out_hi_q;
  assign rsp_o.removed_count = out_rem_q;
  assign rsp_o.occupancy     = out_occ_q;

endmodule

### hdl/crtq_checker.sv
module crtq_checker #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned ID_BITS     = 8,
  parameter int unsigned INDEX_BITS  = 21
) (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               rsp_valid_i,
  input logic                               rsp_ready_i,
  input logic [crtq_pkg::STATUS_W-1:0]      status_i,
  input logic [ID_BITS-1:0]                 out_id_i,
  input logic [INDEX_BITS-1:0]              out_begin_i,
  input logic [INDEX_BITS-1:0]              out_end_i,
  input logic [$clog2(QUEUE_DEPTH+1)-1:0]   removed_count_i,
  input logic [$clog2(QUEUE_DEPTH+1)-1:0]   occupancy_i
);
  import crtq_pkg::*;

  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  // a full drop only happens with every slot taken
  a_full_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && status_i == ST_FULL |-> occupancy_i == CNT_W'(QUEUE_DEPTH))
    else $error("dropped-full with spare room");

  a_append_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && status_i == ST_APPENDED |-> occupancy_i != '0)
    else $error("append left the queue empty");

  a_rem_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && removed_count_i != '0 |-> status_i == ST_REMOVED)
    else $error("removed count on a non-remove transaction");

  a_empty_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && status_i == ST_EMPTY |->
      out_id_i == '0 && out_begin_i == '0 && out_end_i == '0 && removed_count_i == '0)
    else $error("empty response carries data");

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=>
      rsp_valid_i && $stable(status_i) && $stable(out_id_i) && $stable(occupancy_i))
    else $error("stalled response transaction changed");

endmodule

bind coalescing_range_task_queue crtq_checker #(
  .QUEUE_DEPTH(QUEUE_DEPTH),
  .ID_BITS    (ID_BITS),
  .INDEX_BITS (INDEX_BITS)
) u_crtq_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .rsp_valid_i    (rsp_o.valid),
  .rsp_ready_i    (rsp_o.ready),
  .status_i       (rsp_o.status),
  .out_id_i       (rsp_o.out_id),
  .out_begin_i    (rsp_o.out_begin),
  .out_end_i      (rsp_o.out_end),
  .removed_count_i(rsp_o.removed_count),
  .occupancy_i    (rsp_o.occupancy)
);

### dv/coalescing_range_task_queue_test.sv
// Self-checking bench for coalescing_range_task_queue.
// A shadow queue follows every request transaction the block takes and
// works out the response transaction it must give; responses are compared
// field by field in order. Sender and receiver idle at random in the first
// two of three phases, and the receiver holds off for a long stretch at least
// once so that the block parks a response and then stalls its request channel.
module coalescing_range_task_queue_test;
  import crtq_pkg::*;

  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned ID_BITS     = 8;
  localparam int unsigned INDEX_BITS  = 21;
  localparam int unsigned CNT_BITS    = 5;

  // func 3 is unused by the block: it must leave the queue alone
  localparam logic [FUNC_W-1:0]  FUNC_SPARE = 2'd3;
  localparam logic [ID_BITS-1:0] MARKER_ID  = '0;

  localparam logic signed [INDEX_BITS-1:0] IDX_MIN = {1'b1, {(INDEX_BITS-1){1'b0}}};
  localparam logic signed [INDEX_BITS-1:0] IDX_MAX = {1'b0, {(INDEX_BITS-1){1'b1}}};

  localparam int unsigned RANDOM_PER_PHASE = 175;
  // long receiver hold-off; the watchdog limit sits well above it and above
  // the worst case of a full-queue walk
  localparam int unsigned HOLD_OFF_CYCLES = 400;
  localparam int unsigned STALL_LIMIT     = 3000;
  localparam int unsigned DRAIN_CYCLES    = 60;

  typedef struct {
    logic [FUNC_W-1:0]            func;
    logic [ID_BITS-1:0]           task_id;
    logic signed [INDEX_BITS-1:0] range_begin;
    logic signed [INDEX_BITS-1:0] range_end;
  } request_t;

  typedef struct {
    logic [STATUS_W-1:0]          status;
    logic [ID_BITS-1:0]           out_id;
    logic signed [INDEX_BITS-1:0] out_begin;
    logic signed [INDEX_BITS-1:0] out_end;
    logic [CNT_BITS-1:0]          removed_count;
    logic [CNT_BITS-1:0]          occupancy;
  } outcome_t;

  typedef struct {
    logic [ID_BITS-1:0]           id;
    logic signed [INDEX_BITS-1:0] lo;
    logic signed [INDEX_BITS-1:0] hi;
  } entry_t;

  // Shadow of the queue contents plus the responses still owed.
  class queue_shadow;
    entry_t      slots[$];
    outcome_t    expected_outcomes[$];
    int unsigned failures;

    function void note_request(request_t r);
      outcome_t            o;
      entry_t              e;
      entry_t              kept[$];
      bit                  folded;
      logic [CNT_BITS-1:0] dropped;
      o.status        = ST_EMPTY;
      o.out_id        = '0;
      o.out_begin     = '0;
      o.out_end       = '0;
      o.removed_count = '0;
      folded          = 1'b0;
      dropped         = '0;
      case (r.func)
        FUNC_ENQ: begin
          if (r.task_id != MARKER_ID) begin
            // widen the first entry of the same id, signed min/max
            foreach (slots[i]) begin
              if (!folded && slots[i].id == r.task_id) begin
                e = slots[i];
                if (e.lo > r.range_begin) e.lo = r.range_begin;
                if (e.hi < r.range_end) e.hi = r.range_end;
                slots[i] = e;
                folded = 1'b1;
              end
            end
          end else if (slots.size() > 0 && slots[slots.size()-1].id == MARKER_ID) begin
            // marker behind a marker is swallowed
            folded = 1'b1;
          end
          if (folded) begin
            o.status = ST_MERGED;
          end else if (slots.size() >= QUEUE_DEPTH) begin
            o.status = ST_FULL;
          end else begin
            e.id = r.task_id;
            e.lo = r.range_begin;
            e.hi = r.range_end;
            slots.push_back(e);
            o.status = ST_APPENDED;
          end
        end
        FUNC_DEQ: begin
          if (slots.size() > 0) begin
            e = slots.pop_front();
            if (e.id == MARKER_ID) begin
              o.status = ST_MARKER;
            end else if (e.hi > 0) begin
              // single-index range above zero reports one index lower
              if (e.lo == e.hi && e.lo > 0) e.lo = e.lo - INDEX_BITS'(1);
              o.status = ST_RANGE;
            end else begin
              o.status = ST_WHOLE;
            end
            o.out_id    = e.id;
            o.out_begin = e.lo;
            o.out_end   = e.hi;
          end
        end
        FUNC_REMOVE: begin
          foreach (slots[i]) begin
            if (slots[i].id == r.task_id) dropped++;
            else kept.push_back(slots[i]);
          end
          slots           = kept;
          o.removed_count = dropped;
          o.status        = ST_REMOVED;
        end
        default: o.status = ST_EMPTY;
      endcase
      o.occupancy = CNT_BITS'(slots.size());
      expected_outcomes.push_back(o);
    endfunction

    function void compare_field(string what, int want, int got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
        failures++;
      end
    endfunction

    function void check_response(outcome_t got);
      outcome_t want;
      if (expected_outcomes.size() == 0) begin
        $display("%0t: response with nothing outstanding, status %0d", $time, got.status);
        failures++;
        return;
      end
      want = expected_outcomes.pop_front();
      compare_field("status", want.status, got.status);
      compare_field("out_id", want.out_id, got.out_id);
      compare_field("out_begin", want.out_begin, got.out_begin);
      compare_field("out_end", want.out_end, got.out_end);
      compare_field("removed_count", want.removed_count, got.removed_count);
      compare_field("occupancy", want.occupancy, got.occupancy);
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  crtq_req_if #(.ID_BITS(ID_BITS), .INDEX_BITS(INDEX_BITS)) req_if ();
  crtq_rsp_if #(.ID_BITS(ID_BITS), .INDEX_BITS(INDEX_BITS), .CNT_BITS(CNT_BITS)) rsp_if ();

  coalescing_range_task_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .ID_BITS    (ID_BITS),
    .INDEX_BITS (INDEX_BITS)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  queue_shadow book;

  int unsigned src_idle_pct;
  int unsigned snk_idle_pct;
  bit          hold_off_pending;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Index values biased towards the interesting corners: equal bounds,
  // whole requests (end at or below zero), the signed extremes, and
  // fully random patterns so every bit toggles.
  function automatic logic signed [INDEX_BITS-1:0] pick_index();
    logic [31:0] raw;
    case ($urandom_range(5))
      0: raw = $urandom_range(3);
      1: raw = $urandom_range(40);
      2: raw = -$urandom_range(2);
      3: raw = $urandom();
      4: begin
        case ($urandom_range(4))
          0: raw = 32'(IDX_MIN);
          1: raw = 32'h001F_FFFF;
          2: raw = 32'd0;
          3: raw = 32'd1;
          default: raw = 32'(IDX_MAX);
        endcase
      end
      default: raw = $urandom_range(1048575);
    endcase
    return raw[INDEX_BITS-1:0];
  endfunction

  // One request transaction: optional idle gap, then hold valid until the
  // block takes it. Returns on the falling edge after acceptance.
  task automatic send_request(input logic [FUNC_W-1:0] func,
                              input logic [ID_BITS-1:0] id,
                              input logic signed [INDEX_BITS-1:0] lo,
                              input logic signed [INDEX_BITS-1:0] hi);
    while ($urandom_range(99) < src_idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_if.valid       <= 1'b1;
    req_if.func        <= func;
    req_if.task_id     <= id;
    req_if.range_begin <= lo;
    req_if.range_end   <= hi;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Receiver: random ready per cycle, or a long hold-off on request.
  always @(negedge clk_i) begin
    if (hold_off_pending) begin
      rsp_if.ready <= 1'b0;
      repeat (HOLD_OFF_CYCLES) @(negedge clk_i);
      hold_off_pending = 1'b0;
    end else begin
      rsp_if.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // Both channels sampled on the rising edge; responses first, as the
  // response of a transaction can never share its request's edge.
  always @(posedge clk_i) begin : monitor
    outcome_t seen;
    request_t taken;
    if (rst_ni) begin
      if (rsp_if.valid && rsp_if.ready) begin
        seen.status        = rsp_if.status;
        seen.out_id        = rsp_if.out_id;
        seen.out_begin     = rsp_if.out_begin;
        seen.out_end       = rsp_if.out_end;
        seen.removed_count = rsp_if.removed_count;
        seen.occupancy     = rsp_if.occupancy;
        book.check_response(seen);
      end
      if (req_if.valid && req_if.ready) begin
        taken.func        = req_if.func;
        taken.task_id     = req_if.task_id;
        taken.range_begin = req_if.range_begin;
        taken.range_end   = req_if.range_end;
        book.note_request(taken);
      end
    end
  end

  // Ends the run if no transaction moves on either channel for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) quiet = 0;
      else quiet++;
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    logic [31:0]                  raw;
    logic [FUNC_W-1:0]            func;
    logic [ID_BITS-1:0]           id;
    logic signed [INDEX_BITS-1:0] lo;
    logic signed [INDEX_BITS-1:0] hi;
    book               = new();
    rst_ni             = 1'b0;
    req_if.valid       = 1'b0;
    req_if.func        = FUNC_ENQ;
    req_if.task_id     = '0;
    req_if.range_begin = '0;
    req_if.range_end   = '0;
    rsp_if.ready       = 1'b0;
    hold_off_pending   = 1'b0;
    src_idle_pct       = 34;
    snk_idle_pct       = 59;

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // --- directed ---
    // empty queue: dequeue and the unused code both report empty
    send_request(FUNC_DEQ, 8'd9, 21'sd0, 21'sd0);
    send_request(FUNC_SPARE, 8'hA5, IDX_MAX, IDX_MIN);
    // a marker, then a second one swallowed behind it
    send_request(FUNC_ENQ, MARKER_ID, 21'sd4, 21'sd9);
    send_request(FUNC_ENQ, MARKER_ID, 21'sd0, 21'sd0);
    // append then widen on both sides
    send_request(FUNC_ENQ, 8'd5, 21'sd10, 21'sd10);
    send_request(FUNC_ENQ, 8'd5, 21'sd3, 21'sd20);
    send_request(FUNC_ENQ, 8'd255, IDX_MIN, IDX_MAX);
    // single index range, adjusted on the way out
    send_request(FUNC_ENQ, 8'd1, 21'sd7, 21'sd7);
    // whole requests, then a merge of a whole request with plain min/max
    send_request(FUNC_ENQ, 8'd2, 21'sd100, 21'sd0);
    send_request(FUNC_ENQ, 8'd3, 21'sd0, -21'sd1);
    send_request(FUNC_ENQ, 8'd2, 21'sd50, -21'sd5);
    send_request(FUNC_ENQ, MARKER_ID, 21'sd0, 21'sd0);
    send_request(FUNC_ENQ, 8'd4, 21'sd1, 21'sd1);
    // fill to the brim
    for (int k = 0; k < 8; k++) begin
      raw = $urandom();
      send_request(FUNC_ENQ, ID_BITS'(200 + k), raw[INDEX_BITS-1:0], pick_index());
    end
    // full: new id and a marker are dropped, an existing id still merges
    send_request(FUNC_ENQ, 8'd77, 21'sd1, 21'sd2);
    send_request(FUNC_ENQ, MARKER_ID, 21'sd0, 21'sd0);
    send_request(FUNC_ENQ, 8'd5, 21'sd0, 21'sd30);
    // drop both markers, then pop a couple
    send_request(FUNC_REMOVE, MARKER_ID, 21'sd0, 21'sd0);
    send_request(FUNC_DEQ, 8'd0, 21'sd0, 21'sd0);
    send_request(FUNC_DEQ, 8'd0, 21'sd0, 21'sd0);

    // --- random, three phases of idle settings ---
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          src_idle_pct = 34;
          snk_idle_pct = 59;
        end
        1: begin
          src_idle_pct = 59;
          snk_idle_pct = 34;
        end
        default: begin
          src_idle_pct = 0;
          snk_idle_pct = 0;
        end
      endcase
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        // long receiver stall while the sender keeps offering
        if (n == 60 && phase != 1) hold_off_pending = 1'b1;
        // small id pools give merges and multi-entry removes
        case ($urandom_range(2))
          0: raw = $urandom_range(3);
          1: raw = $urandom_range(31);
          default: raw = $urandom_range(255);
        endcase
        id = raw[ID_BITS-1:0];
        lo = pick_index();
        hi = ($urandom_range(3) == 0) ? lo : pick_index();
        raw = $urandom_range(99);
        if (raw < 48) begin
          func = FUNC_ENQ;
          if ($urandom_range(9) == 0) id = MARKER_ID;
        end else if (raw < 78) begin
          func = FUNC_DEQ;
        end else if (raw < 95) begin
          func = FUNC_REMOVE;
        end else begin
          func = FUNC_SPARE;
        end
        send_request(func, id, lo, hi);
      end
    end
    req_if.valid <= 1'b0;

    // drain, then leave room for any stray response
    while (book.expected_outcomes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (book.failures == 0 && book.expected_outcomes.size() == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
